// ===== sv/atpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the tile push resolver: the request record, the push word
// and the per-tile overlap result. No dependencies.
package atpr_pkg;

    localparam int CoordW = 20;
    localparam int DimW   = 16;
    localparam int PushW  = 17;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic        [DimW-1:0]   dim_t;
    typedef logic signed [PushW-1:0]  push_t;

    typedef struct packed {
        coord_t entity_left;
        coord_t entity_top;
        dim_t   entity_width;
        dim_t   entity_height;
        coord_t tile_left;
        coord_t tile_top;
        dim_t   tile_width;
        dim_t   tile_height;
        logic   last_tile;
    } atpr_req_t;

    typedef struct packed {
        logic  hit;
        logic  axis_x;
        push_t push;
    } atpr_hit_t;

endpackage

// ===== sv/atpr_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: one entity box, one tile box and the last-tile flag.
// Depends on atpr_pkg.
interface atpr_req_if;
    import atpr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t entity_left;
    coord_t entity_top;
    dim_t   entity_width;
    dim_t   entity_height;
    coord_t tile_left;
    coord_t tile_top;
    dim_t   tile_width;
    dim_t   tile_height;
    logic   last_tile;

    modport source (
        output valid, entity_left, entity_top, entity_width, entity_height,
               tile_left, tile_top, tile_width, tile_height, last_tile,
        input  ready
    );

    modport sink (
        input  valid, entity_left, entity_top, entity_width, entity_height,
               tile_left, tile_top, tile_width, tile_height, last_tile,
        output ready
    );
endinterface

// ===== sv/atpr_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: the resolved x and y pushes of one query.
// Depends on atpr_pkg.
interface atpr_rsp_if;
    import atpr_pkg::*;

    logic  valid;
    logic  ready;
    push_t push_x;
    push_t push_y;

    modport source (
        output valid, push_x, push_y,
        input  ready
    );

    modport sink (
        input  valid, push_x, push_y,
        output ready
    );
endinterface

// ===== sv/atpr_in_stage.sv =====
`timescale 1ns / 1ps
// Input register: captures one request and holds it until the next stage
// takes it. Depends on atpr_pkg and atpr_req_if.
module atpr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    atpr_req_if.sink           req,
    input  logic               advance,
    output logic               valid_reg,
    output atpr_pkg::atpr_req_t data_reg
);
    import atpr_pkg::*;

    logic      valid_next;
    logic      load;
    atpr_req_t data_next;

    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        data_next.entity_left   = req.entity_left;
        data_next.entity_top    = req.entity_top;
        data_next.entity_width  = req.entity_width;
        data_next.entity_height = req.entity_height;
        data_next.tile_left     = req.tile_left;
        data_next.tile_top      = req.tile_top;
        data_next.tile_width    = req.tile_width;
        data_next.tile_height   = req.tile_height;
        data_next.last_tile     = req.last_tile;
        valid_next              = load || (valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end
endmodule

// ===== sv/atpr_overlap.sv =====
`timescale 1ns / 1ps
// Overlap test for one entity/tile pair: strict overlap, doubled centre
// offsets and the signed push on the chosen axis. Depends on atpr_pkg.
module atpr_overlap (
    input  atpr_pkg::atpr_req_t data,
    output atpr_pkg::atpr_hit_t result
);
    import atpr_pkg::*;

    logic signed [CoordW:0]   e_x0, e_x1, t_x0, t_x1;
    logic signed [CoordW:0]   e_y0, e_y1, t_y0, t_y1;
    logic signed [CoordW:0]   ox0, ox1, oy0, oy1;
    logic signed [CoordW:0]   ow, oh;
    logic signed [CoordW+2:0] e_cx, t_cx, e_cy, t_cy, dx, dy;
    logic        [CoordW+2:0] adx, ady;
    logic                     dx_pos, dy_pos;

    always_comb
    begin
        e_x0 = (CoordW+1)'(data.entity_left);
        e_x1 = e_x0 + $signed({5'b0, data.entity_width});
        t_x0 = (CoordW+1)'(data.tile_left);
        t_x1 = t_x0 + $signed({5'b0, data.tile_width});
        e_y0 = (CoordW+1)'(data.entity_top);
        e_y1 = e_y0 + $signed({5'b0, data.entity_height});
        t_y0 = (CoordW+1)'(data.tile_top);
        t_y1 = t_y0 + $signed({5'b0, data.tile_height});

        ox0 = (e_x0 > t_x0) ? e_x0 : t_x0;
        ox1 = (e_x1 < t_x1) ? e_x1 : t_x1;
        oy0 = (e_y0 > t_y0) ? e_y0 : t_y0;
        oy1 = (e_y1 < t_y1) ? e_y1 : t_y1;
        ow  = ox1 - ox0;
        oh  = oy1 - oy0;

        e_cx = $signed({{2{data.entity_left[CoordW-1]}}, data.entity_left, 1'b0})
             + $signed({7'b0, data.entity_width});
        t_cx = $signed({{2{data.tile_left[CoordW-1]}}, data.tile_left, 1'b0})
             + $signed({7'b0, data.tile_width});
        e_cy = $signed({{2{data.entity_top[CoordW-1]}}, data.entity_top, 1'b0})
             + $signed({7'b0, data.entity_height});
        t_cy = $signed({{2{data.tile_top[CoordW-1]}}, data.tile_top, 1'b0})
             + $signed({7'b0, data.tile_height});
        dx = e_cx - t_cx;
        dy = e_cy - t_cy;

        adx    = dx[CoordW+2] ? (CoordW+3)'(-dx) : (CoordW+3)'(dx);
        ady    = dy[CoordW+2] ? (CoordW+3)'(-dy) : (CoordW+3)'(dy);
        dx_pos = !dx[CoordW+2] && (dx != '0);
        dy_pos = !dy[CoordW+2] && (dy != '0);

        result.hit    = (ox0 < ox1) && (oy0 < oy1);
        result.axis_x = adx > ady;
        if (result.axis_x)
        begin
            result.push = dx_pos ? push_t'(ow[PushW-1:0]) : push_t'(-ow[PushW-1:0]);
        end
        else
        begin
            result.push = dy_pos ? push_t'(oh[PushW-1:0]) : push_t'(-oh[PushW-1:0]);
        end
    end
endmodule

// ===== sv/atpr_accum.sv =====
`timescale 1ns / 1ps
// Held push state and result register: applies each tile's push, and on the
// last tile hands the pushes out and clears them. Depends on atpr_pkg, atpr_rsp_if.
module atpr_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                last,
    input  atpr_pkg::atpr_hit_t hit,
    output logic                free,
    atpr_rsp_if.source          rsp
);
    import atpr_pkg::*;

    push_t held_x_reg, held_x_next;
    push_t held_y_reg, held_y_next;
    push_t upd_x, upd_y;
    push_t out_x_reg, out_y_reg;
    logic  out_valid_reg, out_valid_next;
    logic  emit;

    assign free       = !out_valid_reg || rsp.ready;
    assign emit       = take && last;
    assign rsp.valid  = out_valid_reg;
    assign rsp.push_x = out_x_reg;
    assign rsp.push_y = out_y_reg;

    always_comb
    begin
        upd_x = (hit.hit && hit.axis_x)  ? hit.push : held_x_reg;
        upd_y = (hit.hit && !hit.axis_x) ? hit.push : held_y_reg;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (take)
        begin
            held_x_next = last ? '0 : upd_x;
            held_y_next = last ? '0 : upd_y;
        end
        out_valid_next = emit || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg <= upd_x;
            out_y_reg <= upd_y;
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> free)
        else $error("result issued while result register still full");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (held_x_reg == '0) && (held_y_reg == '0) && out_valid_reg)
        else $error("held pushes not cleared after last tile");

    a_miss_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        take && !last && !hit.hit |=> $stable(held_x_reg) && $stable(held_y_reg))
        else $error("held push changed on a tile with no overlap");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        take && hit.hit |-> hit.push != '0)
        else $error("overlapping tile produced a zero push");
endmodule

// ===== sv/aabb_tile_push_resolver_top.sv =====
`timescale 1ns / 1ps
// Top level of the tile push resolver: input register, overlap logic and
// push accumulator. Depends on atpr_pkg, atpr_req_if, atpr_rsp_if and submodules.
//
// Takes one request per cycle while no last-tile request waits; each carries the
// entity box and one tile box. A request is registered, tested for overlap in a
// single pass of compares and adds, and its push folded into the held x/y pushes
// as it leaves the input register. On a request marked last tile a result with
// both pushes is loaded into the result register once that register is free, and
// the held pushes return to zero. Throughput is one request per cycle, set by the
// single overlap stage between input and result registers; only a last-tile
// request waits, while an earlier result is still untaken.
module aabb_tile_push_resolver_top (
    input  logic       clk,
    input  logic       rst_n,
    atpr_req_if.sink   req,
    atpr_rsp_if.source rsp
);
    import atpr_pkg::*;

    logic      s1_valid;
    atpr_req_t s1_data;
    atpr_hit_t s1_hit;
    logic      advance;
    logic      free;

    assign advance = s1_valid && (!s1_data.last_tile || free);

    atpr_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .advance   (advance),
        .valid_reg (s1_valid),
        .data_reg  (s1_data)
    );

    atpr_overlap u_overlap (
        .data   (s1_data),
        .result (s1_hit)
    );

    atpr_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (advance),
        .last  (s1_data.last_tile),
        .hit   (s1_hit),
        .free  (free),
        .rsp   (rsp)
    );
endmodule
